[rtl/projected_gauss_seidel_contact_solver_defines.svh]
// ----------------------------------------------------------------------------
// pgs assertion macros
// shared concurrent assertion forms for the contact solver rtl
// ----------------------------------------------------------------------------
`ifndef PROJECTED_GAUSS_SEIDEL_CONTACT_SOLVER_DEFINES_SVH
`define PROJECTED_GAUSS_SEIDEL_CONTACT_SOLVER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PGS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgs assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define PGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgs assertion failed");

`endif

[rtl/pgs_pkg.sv]
// ----------------------------------------------------------------------------
// pgs package
// shared constants, types and saturation helpers of the contact solver
// ----------------------------------------------------------------------------
package pgs_pkg;

    localparam int MAX_CONTACTS = 16;
    localparam int FRAC_BITS    = 16;
    localparam int VEC_LEN      = 2 * MAX_CONTACTS;
    localparam int DATA_W       = 32;
    localparam int WIDE_W       = 64;
    localparam int ROW_W        = $clog2(VEC_LEN);
    localparam int MU_AW        = $clog2(MAX_CONTACTS);
    localparam int MAT_AW       = 2 * ROW_W;
    localparam int CNT_W        = $clog2(MAX_CONTACTS + 1);
    localparam int LEN_W        = $clog2(VEC_LEN + 1);
    localparam int REQ_W        = 3;
    localparam int CFG_AW       = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_MAT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_RHS = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LOAD_MU  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LOAD_LAM = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SOLVE    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_CONTACTS   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SWEEPS     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_COMPLIANCE = 2'd2;

    // divide request to the shared divider
    typedef struct packed {
        logic                     go;
        logic signed [WIDE_W-1:0] num;
        logic signed [WIDE_W-1:0] den;
    } div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } div_rsp_t;

    function automatic logic signed [WIDE_W-1:0] sat64(input logic signed [WIDE_W:0] v);
        logic signed [WIDE_W-1:0] r;
        if (v[WIDE_W] != v[WIDE_W-1])
            r = v[WIDE_W] ? {1'b1, {(WIDE_W-1){1'b0}}} : {1'b0, {(WIDE_W-1){1'b1}}};
        else
            r = v[WIDE_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > WIDE_W'(signed'({1'b0, {(DATA_W-1){1'b1}}})))
            r = {1'b0, {(DATA_W-1){1'b1}}};
        else if (v < -WIDE_W'(signed'({1'b0, {(DATA_W-1){1'b1}}})) - WIDE_W'(1))
            r = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

[rtl/pgs_div.sv]
// ----------------------------------------------------------------------------
// pgs divider
// restoring 64 by 64 signed divide, one quotient bit per cycle, saturated
// ----------------------------------------------------------------------------
module pgs_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pgs_pkg::div_req_t req,
    output pgs_pkg::div_rsp_t rsp
);

    localparam int W   = pgs_pkg::WIDE_W;
    localparam int DW  = pgs_pkg::DATA_W;
    localparam int CW  = $clog2(W);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dmag_reg, dmag_next;
    logic          neg_reg, neg_next;
    logic          zero_reg, zero_next;
    logic          done_reg, done_next;
    logic signed [DW-1:0] quot_reg, quot_next;

    logic [W:0]   rem_sh;
    logic [W:0]   diff;

    assign rem_sh = {rem_reg[W-1:0], quo_reg[W-1]};
    assign diff   = rem_sh - {1'b0, dmag_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        if (req.go)
        begin
            // magnitudes; the most negative value maps to 2^63 unsigned
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.num[W-1] ? (W'(0) - req.num) : req.num;
            dmag_next = req.den[W-1] ? (W'(0) - req.den) : req.den;
            neg_next  = req.num[W-1] ^ req.den[W-1];
            zero_next = (req.den == '0);
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (zero_reg)
                    quot_next = '0;
                else if (neg_reg)
                    quot_next = (quo_next >= (W'(1) << (DW - 1)))
                        ? {1'b1, {(DW-1){1'b0}}} : DW'(W'(0) - quo_next);
                else
                    quot_next = (quo_next > W'({1'b0, {(DW-1){1'b1}}}))
                        ? {1'b0, {(DW-1){1'b1}}} : quo_next[DW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

[rtl/projected_gauss_seidel_contact_solver.sv]
// ----------------------------------------------------------------------------
// projected gauss-seidel contact solver
// loads a dense system, then runs projected gauss-seidel sweeps over the
// contacts with one shared multiplier, accumulator and divider
// ----------------------------------------------------------------------------
//
// channel   | handshake                | payload
// ----------+--------------------------+------------------------------------------
// request   | start, busy              | req_type, row_index, col_index, load_value
// config    | cfg_we                   | cfg_index, cfg_data
// result    | done (one-cycle strobe)  | entry_index, impulse_value, last_entry
//
// a load word does not raise busy; busy stays low and the next word may follow
// a solve word runs sweep_count * N * (up to two rows); each row reads, multiplies
// and accumulates each of its 2N columns through the one multiplier and the
// saturating accumulator, then reads the diagonal, launches the divide and waits on it;
// a normal row with friction adds a mu * normal product for the cone bound
// after the sweeps, 2N result words leave one by one through the lambda read port
// reset clears control state and the registers to 1, 1, 0; the stores hold
// garbage until loaded; results cannot be stalled by the receiver
//
`include "projected_gauss_seidel_contact_solver_defines.svh"

module projected_gauss_seidel_contact_solver (
    input  logic                                clk,
    input  logic                                rst_n,
    // request words
    input  logic                                start,
    output logic                                busy,
    input  logic [pgs_pkg::REQ_W-1:0]           req_type,
    input  logic [pgs_pkg::ROW_W-1:0]           row_index,
    input  logic [pgs_pkg::ROW_W-1:0]           col_index,
    input  logic signed [pgs_pkg::DATA_W-1:0]   load_value,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [pgs_pkg::CFG_AW-1:0]          cfg_index,
    input  logic [pgs_pkg::DATA_W-1:0]          cfg_data,
    // result words
    output logic                                done,
    output logic [pgs_pkg::ROW_W-1:0]           entry_index,
    output logic signed [pgs_pkg::DATA_W-1:0]   impulse_value,
    output logic                                last_entry
);

    localparam int DW   = pgs_pkg::DATA_W;
    localparam int WW   = pgs_pkg::WIDE_W;
    localparam int RW   = pgs_pkg::ROW_W;
    localparam int CW   = pgs_pkg::CNT_W;
    localparam int LW   = pgs_pkg::LEN_W;
    localparam int FB   = pgs_pkg::FRAC_BITS;
    localparam int SW   = 16;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_RD    = 14'b00000000000010,  // read matrix and lambda at column
        S_MUL   = 14'b00000000000100,  // product
        S_ACC   = 14'b00000000001000,  // saturating accumulate
        S_DRD   = 14'b00000000010000,  // read diagonal, lambda[i], b[i], mu
        S_DMUL  = 14'b00000000100000,  // lambda[i] * diagonal
        S_NUM   = 14'b00000001000000,  // subtract scaled b
        S_DIVGO = 14'b00000010000000,  // subtract sum, launch divide
        S_DIV   = 14'b00000100000000,  // wait for quotient
        S_WB    = 14'b00001000000000,  // project and write back
        S_UBMUL = 14'b00010000000000,  // mu * normal
        S_UB    = 14'b00100000000000,  // friction bound
        S_ORD   = 14'b01000000000000,  // read lambda for output
        S_OWR   = 14'b10000000000000   // drive result word
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CW-1:0]        contacts_reg;
    logic [SW-1:0]        sweeps_reg;
    logic signed [DW-1:0] compliance_reg;

    // stores
    logic signed [DW-1:0] mat_mem [2**pgs_pkg::MAT_AW];
    logic signed [DW-1:0] rhs_mem [pgs_pkg::VEC_LEN];
    logic signed [DW-1:0] mu_mem  [pgs_pkg::MAX_CONTACTS];
    logic signed [DW-1:0] lam_mem [pgs_pkg::VEC_LEN];

    logic signed [DW-1:0] mat_rd_reg, rhs_rd_reg, mu_rd_reg, lam_rd_reg;

    // sequencer counters and datapath registers
    logic [CW-1:0]        contact_reg, contact_next;
    logic                 tang_reg, tang_next;
    logic [RW-1:0]        col_reg, col_next;
    logic [SW-1:0]        sweep_reg, sweep_next;
    logic signed [WW-1:0] prod_reg, acc_reg, acc_next, num_reg;
    logic signed [DW-1:0] diag_reg, x_reg, ub_reg, x_next, ub_next;
    logic                 done_reg, last_reg;
    logic [RW-1:0]        eidx_reg;
    logic signed [DW-1:0] eval_reg;

    pgs_pkg::div_req_t    div_req_reg, div_req_next;
    pgs_pkg::div_rsp_t    div_rsp;

    logic [CW-1:0]        n_act;
    logic [LW-1:0]        n2;
    logic [RW-1:0]        row;
    logic                 req_ok;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [WW-1:0] prod_next;
    logic signed [WW-1:0] rhs_scaled;
    logic signed [WW-1:0] den;
    logic                 lam_we;
    logic [RW-1:0]        lam_waddr, lam_raddr;
    logic signed [DW-1:0] lam_wdata, wb_value;
    logic signed [DW:0]   t33, ub33, nub33, tc33;
    logic                 last_col, last_contact, last_sweep;

    // active contacts saturate at the store size
    assign n_act = (contacts_reg > CW'(pgs_pkg::MAX_CONTACTS))
                   ? CW'(pgs_pkg::MAX_CONTACTS) : contacts_reg;
    assign n2    = {n_act, 1'b0};
    assign row   = {contact_reg[RW-2:0], tang_reg};
    assign req_ok = start && !busy;
    assign busy  = (state_reg != S_IDLE);

    assign last_col     = (LW'(col_reg) + LW'(1) == n2);
    assign last_contact = (contact_reg + CW'(1) == n_act);
    assign last_sweep   = (sweep_reg + SW'(1) == sweeps_reg);

    // the one shared multiplier
    assign mul_a     = (state_reg == S_UBMUL) ? mu_rd_reg : mat_rd_reg;
    assign mul_b     = (state_reg == S_UBMUL) ? x_reg : lam_rd_reg;
    assign prod_next = mul_a * mul_b;

    assign rhs_scaled = {{(WW-DW-FB){rhs_rd_reg[DW-1]}}, rhs_rd_reg, {FB{1'b0}}};
    assign den = WW'(diag_reg) + (tang_reg ? WW'(0) : WW'(compliance_reg));

    // tangent projection onto [-ub, ub]; ub is applied last, so a negative ub wins
    assign t33   = {div_rsp.quot[DW-1], div_rsp.quot};
    assign ub33  = {ub_reg[DW-1], ub_reg};
    assign nub33 = -ub33;
    always_comb
    begin
        tc33 = t33;
        if (tc33 < nub33)
            tc33 = nub33;
        if (tc33 > ub33)
            tc33 = ub33;
    end

    always_comb
    begin
        if (!tang_reg)
            wb_value = div_rsp.quot[DW-1] ? '0 : div_rsp.quot;
        else
            wb_value = pgs_pkg::sat32(WW'(tc33));
    end

    // lambda port: loads when idle, solver write-back otherwise
    // the quotient register holds its value through the write-back cycle
    assign lam_we    = (req_ok && req_type == pgs_pkg::REQ_LOAD_LAM)
                       || (state_reg == S_WB);
    assign lam_waddr = (state_reg == S_IDLE) ? row_index : row;
    assign lam_wdata = (state_reg == S_IDLE) ? load_value : wb_value;
    assign lam_raddr = (state_reg == S_RD || state_reg == S_MUL) ? col_reg :
                       (state_reg == S_ORD || state_reg == S_OWR) ? col_reg : row;

    always_ff @(posedge clk)
    begin
        if (req_ok && req_type == pgs_pkg::REQ_LOAD_MAT)
            mat_mem[{row_index, col_index}] <= load_value;
        if (req_ok && req_type == pgs_pkg::REQ_LOAD_RHS)
            rhs_mem[row_index] <= load_value;
        if (req_ok && req_type == pgs_pkg::REQ_LOAD_MU
            && row_index < RW'(pgs_pkg::MAX_CONTACTS))
            mu_mem[row_index[pgs_pkg::MU_AW-1:0]] <= load_value;
        if (lam_we)
            lam_mem[lam_waddr] <= lam_wdata;
        mat_rd_reg <= mat_mem[(state_reg == S_DRD) ? {row, row} : {row, col_reg}];
        rhs_rd_reg <= rhs_mem[row];
        mu_rd_reg  <= mu_mem[contact_reg[pgs_pkg::MU_AW-1:0]];
        lam_rd_reg <= lam_mem[lam_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        contact_next = contact_reg;
        tang_next    = tang_reg;
        col_next     = col_reg;
        sweep_next   = sweep_reg;
        acc_next     = acc_reg;
        x_next       = x_reg;
        ub_next      = ub_reg;
        div_req_next = div_req_reg;
        div_req_next.go = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_ok && req_type == pgs_pkg::REQ_SOLVE && n_act != '0)
                begin
                    contact_next = '0;
                    tang_next    = 1'b0;
                    col_next     = '0;
                    sweep_next   = '0;
                    acc_next     = '0;
                    state_next   = (sweeps_reg == '0) ? S_ORD : S_RD;
                end
            end
            S_RD:    state_next = S_MUL;
            S_MUL:   state_next = S_ACC;
            S_ACC:
            begin
                acc_next = pgs_pkg::sat64({acc_reg[WW-1], acc_reg} + {prod_reg[WW-1], prod_reg});
                col_next = col_reg + RW'(1);
                state_next = last_col ? S_DRD : S_RD;
            end
            S_DRD:   state_next = S_DMUL;
            S_DMUL:  state_next = S_NUM;
            S_NUM:   state_next = S_DIVGO;
            S_DIVGO:
            begin
                div_req_next.go  = 1'b1;
                div_req_next.num = pgs_pkg::sat64({num_reg[WW-1], num_reg}
                                                  - {acc_reg[WW-1], acc_reg});
                div_req_next.den = den;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                    state_next = S_WB;
            end
            S_WB:
            begin
                x_next   = wb_value;
                col_next = '0;
                acc_next = '0;
                if (!tang_reg && mu_rd_reg != '0)
                    state_next = S_UBMUL;
                else
                begin
                    tang_next = 1'b0;
                    if (last_contact)
                    begin
                        contact_next = '0;
                        sweep_next   = sweep_reg + SW'(1);
                        state_next   = last_sweep ? S_ORD : S_RD;
                    end
                    else
                    begin
                        contact_next = contact_reg + CW'(1);
                        state_next   = S_RD;
                    end
                end
            end
            S_UBMUL: state_next = S_UB;
            S_UB:
            begin
                // arithmetic shift rounds toward minus infinity
                ub_next    = pgs_pkg::sat32(prod_reg >>> FB);
                tang_next  = 1'b1;
                state_next = S_RD;
            end
            S_ORD:   state_next = S_OWR;
            S_OWR:
            begin
                col_next   = col_reg + RW'(1);
                state_next = last_col ? S_IDLE : S_ORD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            contacts_reg   <= CW'(1);
            sweeps_reg     <= SW'(1);
            compliance_reg <= '0;
            contact_reg    <= '0;
            tang_reg       <= 1'b0;
            col_reg        <= '0;
            sweep_reg      <= '0;
            div_req_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            contact_reg    <= contact_next;
            tang_reg       <= tang_next;
            col_reg        <= col_next;
            sweep_reg      <= sweep_next;
            div_req_reg    <= div_req_next;
            done_reg       <= (state_reg == S_OWR);
            if (cfg_we)
            begin
                case (cfg_index)
                    pgs_pkg::CFG_CONTACTS:   contacts_reg   <= cfg_data[CW-1:0];
                    pgs_pkg::CFG_SWEEPS:     sweeps_reg     <= cfg_data[SW-1:0];
                    pgs_pkg::CFG_COMPLIANCE: compliance_reg <= cfg_data;
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg        <= prod_next;
        acc_reg         <= acc_next;
        x_reg           <= x_next;
        ub_reg          <= ub_next;
        if (state_reg == S_DMUL)
            diag_reg <= mat_rd_reg;
        if (state_reg == S_NUM)
            num_reg <= pgs_pkg::sat64({prod_reg[WW-1], prod_reg}
                                      - {rhs_scaled[WW-1], rhs_scaled});
        if (state_reg == S_OWR)
        begin
            eidx_reg <= col_reg;
            eval_reg <= lam_rd_reg;
            last_reg <= last_col;
        end
    end

    pgs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    assign done          = done_reg;
    assign entry_index   = eidx_reg;
    assign impulse_value = eval_reg;
    assign last_entry    = last_reg;

    // a run ends on its last word
    `PGS_ASSERT_NEXT(a_run_ends, done && last_entry, !done)
    // more words follow a word that is not last
    `PGS_ASSERT_SAME(a_run_continues, done && !last_entry, busy)
    // quotient arrives only while the sequencer waits for it
    `PGS_ASSERT_SAME(a_div_expected, div_rsp.done, state_reg == S_DIV)

endmodule
